/* rtl/core/ssr_pkg.sv */
// package: shared types and constants for the streaming find-and-replace block
`timescale 1ns / 1ps

package ssr_pkg;

    // sizes of the pattern and replacement strings
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int WIN_DEPTH       = MAX_PATTERN - 1;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // register map, index is paddr[4:3]
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } ssr_reg_idx_t;

    // input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
    } ssr_in_t;

    // output transaction
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [15:0] replacements_so_far;
    } ssr_out_t;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [63:0] pattern;
        logic [3:0]  plen;
        logic [63:0] repl;
        logic [3:0]  rlen;
    } ssr_cfg_t;

    // one unit of work from the front to the back: up to eight bytes
    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  len;
        logic [15:0] rcount;
    } ssr_job_t;

endpackage

/* rtl/core/ssr_regs.sv */
// configuration registers with an apb-style write and read port
`timescale 1ns / 1ps

module ssr_regs
    import ssr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output ssr_cfg_t    cfg
);

    logic [63:0]  pattern_reg;
    logic [3:0]   plen_reg;
    logic [63:0]  repl_reg;
    logic [3:0]   rlen_reg;
    logic         wr_en;
    ssr_reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = ssr_reg_idx_t'(paddr[4:3]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= 4'd1;
            repl_reg    <= '0;
            rlen_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PATTERN_BYTES:      pattern_reg <= pwdata;
                REG_PATTERN_LENGTH:     plen_reg    <= pwdata[3:0];
                REG_REPLACEMENT_BYTES:  repl_reg    <= pwdata;
                REG_REPLACEMENT_LENGTH: rlen_reg    <= pwdata[3:0];
                default:                pattern_reg <= pattern_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_PATTERN_BYTES:      prdata = pattern_reg;
            REG_PATTERN_LENGTH:     prdata = {60'd0, plen_reg};
            REG_REPLACEMENT_BYTES:  prdata = repl_reg;
            REG_REPLACEMENT_LENGTH: prdata = {60'd0, rlen_reg};
            default:                prdata = '0;
        endcase
    end

    // clamp lengths into their legal ranges
    always_comb
    begin
        cfg.pattern = pattern_reg;
        cfg.repl    = repl_reg;
        if (plen_reg == 4'd0)
            cfg.plen = 4'd1;
        else if (plen_reg > 4'(MAX_PATTERN))
            cfg.plen = 4'(MAX_PATTERN);
        else
            cfg.plen = plen_reg;
        if (rlen_reg > 4'(MAX_REPLACEMENT))
            cfg.rlen = 4'(MAX_REPLACEMENT);
        else
            cfg.rlen = rlen_reg;
    end

endmodule

/* rtl/core/ssr_front.sv */
// front end: takes input transactions, runs the window search, issues jobs
`timescale 1ns / 1ps

module ssr_front
    import ssr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ssr_cfg_t cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  ssr_in_t  in_data,
    input  logic     queue_full,
    output logic     push,
    output ssr_job_t push_job
);

    logic [7:0]  win_reg [WIN_DEPTH];
    logic [7:0]  win_next [WIN_DEPTH];
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [15:0] rcnt_reg;
    logic [15:0] rcnt_next;

    logic        accept;
    logic [3:0]  held;
    logic [3:0]  held_after;
    logic [7:0]  cur [MAX_PATTERN];
    logic [63:0] cur_word;
    logic [63:0] shifted;
    logic [MAX_PATTERN-1:0] ok;
    logic [3:0]  drop;
    logic        match;

    assign in_stall = queue_full;
    assign accept   = in_valid & ~in_stall;

    // held bytes, trimmed to the current pattern length
    always_comb
    begin
        if ({1'b0, count_reg} > cfg.plen - 4'd1)
            held = cfg.plen - 4'd1;
        else
            held = {1'b0, count_reg};
        held_after = held + 4'd1;
    end

    // window with the new byte appended
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (i < WIN_DEPTH && 4'(i) < held)
                cur[i] = win_reg[i < WIN_DEPTH ? i : 0];
            else
                cur[i] = in_data.data_byte;
            cur_word[8*i +: 8] = cur[i];
        end
    end

    // prefix check at every shift in parallel
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            ok[k] = 1'b1;
            for (int i = 0; i < MAX_PATTERN - k; i++)
            begin
                if (4'(k + i) < held_after)
                begin
                    if (cur[k + i] != cfg.pattern[8*i +: 8])
                        ok[k] = 1'b0;
                    if (cur[k + i] == NEWLINE_BYTE && 4'(i) != cfg.plen - 4'd1)
                        ok[k] = 1'b0;
                end
            end
        end
    end

    // smallest shift that leaves a live prefix
    always_comb
    begin
        drop = held_after;
        for (int k = MAX_PATTERN - 1; k >= 0; k--)
        begin
            if (4'(k) < held_after && ok[k])
                drop = 4'(k);
        end
        match   = (drop == 4'd0) && (held_after == cfg.plen);
        shifted = cur_word >> {drop, 3'b000};
    end

    // job and next state
    always_comb
    begin
        count_next = count_reg;
        rcnt_next  = rcnt_reg;
        for (int j = 0; j < WIN_DEPTH; j++)
            win_next[j] = shifted[8*j +: 8];
        push_job.bytes = cur_word;
        push_job.len   = drop;
        if (in_data.flush)
        begin
            push_job.len = held;
            count_next   = 3'd0;
        end
        else if (match)
        begin
            push_job.bytes = cfg.repl;
            push_job.len   = cfg.rlen;
            count_next     = 3'd0;
            if (rcnt_reg != 16'hFFFF)
                rcnt_next = rcnt_reg + 16'd1;
        end
        else
        begin
            count_next = 3'(held_after - drop);
        end
        push_job.rcount = rcnt_next;
        push            = accept && (push_job.len != 4'd0);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rcnt_reg  <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            rcnt_reg  <= rcnt_next;
        end
        else
        begin
            // a shorter pattern length drops the newest held bytes for good
            count_reg <= held[2:0];
        end
    end

    // held window bytes
    always_ff @(posedge clk)
    begin
        if (accept && !in_data.flush)
        begin
            for (int j = 0; j < WIN_DEPTH; j++)
                win_reg[j] <= win_next[j];
        end
    end

    // flush leaves nothing held
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.flush) |=> (count_reg == 3'd0))
        else $error("held bytes remain after flush");

    // replacement count never goes down
    a_rcnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rcnt_reg >= $past(rcnt_reg)))
        else $error("replacement count decreased");

endmodule

/* rtl/core/ssr_queue.sv */
// short job queue between the front and back ends
`timescale 1ns / 1ps

module ssr_queue
    import ssr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ssr_job_t push_job,
    output logic     full,
    input  logic     pop,
    output ssr_job_t head,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssr_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue underflow");

endmodule

/* rtl/core/ssr_back.sv */
// back end: plays each job out one byte per output transaction
`timescale 1ns / 1ps

module ssr_back
    import ssr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ssr_job_t head,
    input  logic     empty,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_stall,
    output ssr_out_t out_data
);

    ssr_job_t   job_reg;
    logic       busy_reg;
    logic [2:0] idx_reg;
    logic       is_last;
    logic       take;

    assign is_last   = ({1'b0, idx_reg} == job_reg.len - 4'd1);
    assign take      = busy_reg & ~out_stall;
    assign pop       = (!busy_reg || (take && is_last)) && !empty;
    assign out_valid = busy_reg;

    // output fields
    always_comb
    begin
        out_data.out_byte            = job_reg.bytes[{idx_reg, 3'b000} +: 8];
        out_data.last                = is_last;
        out_data.replacements_so_far = job_reg.rcount;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            if (is_last)
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // current job
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (job_reg.len != 4'd0 && {1'b0, idx_reg} < job_reg.len))
        else $error("byte index outside current job");

endmodule

/* rtl/core/stream_substring_replace_top.sv */
// top level: streaming find-and-replace with config registers, front, queue and back
// path: an input transaction's job is registered in the job queue, then in the back end's
//   job register, which raises out_valid; a busy back end can hold the job in the queue
// throughput: one input transaction per cycle while the job queue is not full; the back end
//   sends one byte per cycle while out_stall is low, and the job queue buffers its jobs
// input stalls only when the job queue is full
// reset: asynchronous active low; clears held count, replacement count, queue and back end;
//   registers reset to pattern_length 1, everything else zero
`timescale 1ns / 1ps

module stream_substring_replace_top
    import ssr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  ssr_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output ssr_out_t    out_data
);

    ssr_cfg_t cfg;
    ssr_job_t push_job;
    ssr_job_t head;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    // configuration registers
    ssr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // search and classify
    ssr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    // job queue
    ssr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    // byte output
    ssr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
